>>> sv/retransmit_dedup_table_defines.svh
// Assertion macros shared by the retransmit dedup table RTL.
// Needs clk and rst_n in scope where a macro is used; no other dependencies.
`ifndef RETRANSMIT_DEDUP_TABLE_DEFINES_SVH
`define RETRANSMIT_DEDUP_TABLE_DEFINES_SVH
`ifndef SYNTH
`define RDT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RDT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RDT_ASSERT(lbl, cond, msg)
`define RDT_ASSERT_IMPL(lbl, ante, cons, msg)
`define RDT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/rdt_pkg.sv
// Package for the retransmit dedup table: field widths, operation codes,
// sequencer states and the structs passed between modules. No dependencies.
`default_nettype none
package rdt_pkg;

  localparam int TAG_W   = 32;
  localparam int LOG_W   = 32;
  localparam int STAMP_W = 40;
  localparam int RSSI_W  = 8;
  localparam int GROUP_W = 16;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic KIND_RETX   = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic [LOG_W-1:0]          logger;
    logic [STAMP_W-1:0]        stamp;
    logic signed [RSSI_W-1:0]  rssi;
  } entry_t;

  typedef struct packed {
    logic                kind;
    logic                found;
    entry_t              data;
    logic [GROUP_W-1:0]  group;
    logic                last;
  } out_item_t;

  // Commands from the sequencer to the output stage.
  typedef struct packed {
    logic                push;
    logic                flush;
    logic                answer;
    logic                found;
    entry_t              data;
    logic [GROUP_W-1:0]  group;
  } out_ctl_t;

  typedef struct packed {
    logic can_push;
    logic out_free;
    logic hold_vld;
  } out_sts_t;

endpackage
`default_nettype wire

>>> sv/rdt_if.sv
// Valid/ready channel interfaces for the retransmit dedup table.
// Depends on rdt_pkg for the field widths.
`default_nettype none
interface rdt_in_if;
  import rdt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [TAG_W-1:0]          tag_id;
  logic [LOG_W-1:0]          logger_id;
  logic [STAMP_W-1:0]        pickup_time;
  logic signed [RSSI_W-1:0]  rssi;

  modport source (output valid, operation, tag_id, logger_id, pickup_time, rssi,
                  input ready);
  modport sink   (input valid, operation, tag_id, logger_id, pickup_time, rssi,
                  output ready);
endinterface

interface rdt_out_if;
  import rdt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      found;
  logic [TAG_W-1:0]          out_tag_id;
  logic [LOG_W-1:0]          out_logger_id;
  logic [STAMP_W-1:0]        out_time;
  logic signed [RSSI_W-1:0]  out_rssi;
  logic [GROUP_W-1:0]        out_group;
  logic                      last;

  modport source (output valid, kind, found, out_tag_id, out_logger_id, out_time,
                  out_rssi, out_group, last, input ready);
  modport sink   (input valid, kind, found, out_tag_id, out_logger_id, out_time,
                  out_rssi, out_group, last, output ready);
endinterface
`default_nettype wire

>>> sv/rdt_entry_mem.sv
// Entry store of the table: payload and retransmit count memories with
// registered read and per-entry valid bits. Depends on rdt_pkg.
`default_nettype none
module rdt_entry_mem #(
  parameter int DEPTH = 8,
  parameter int CNT_W = 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic                      wr_pay_en,
  input  wire logic                      wr_cnt_en,
  input  wire rdt_pkg::entry_t           wr_entry,
  input  wire logic [CNT_W-1:0]          wr_cnt,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output rdt_pkg::entry_t                rd_entry,
  output logic [CNT_W-1:0]               rd_cnt
);
  import rdt_pkg::*;

  entry_t            pay_mem [DEPTH];
  logic [CNT_W-1:0]  cnt_mem [DEPTH];
  logic [DEPTH-1:0]  vld_r, vld_nxt;
  entry_t            rd_entry_r;
  logic [CNT_W-1:0]  rd_cnt_r;

  always_ff @(posedge clk) begin
    if (wr_pay_en) begin
      pay_mem[wr_addr] <= wr_entry;
    end
    if (wr_cnt_en) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (vld_r[rd_addr]) begin
        rd_entry_r <= pay_mem[rd_addr];
        rd_cnt_r   <= cnt_mem[rd_addr];
      end else begin
        rd_entry_r <= '0;
        rd_cnt_r   <= '0;
      end
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (wr_pay_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_cnt   = rd_cnt_r;

endmodule
`default_nettype wire

>>> sv/rdt_out_stage.sv
// Output stage: a hold register for the newest retransmit item and the
// output register towards the result channel. Depends on rdt_pkg and rdt_if.
`default_nettype none
`include "retransmit_dedup_table_defines.svh"
module rdt_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rdt_pkg::out_ctl_t  ctl,
  output rdt_pkg::out_sts_t       sts,
  rdt_out_if.source               out_ch
);
  import rdt_pkg::*;

  logic       hold_vld_r, hold_vld_nxt;
  out_item_t  hold_r, hold_nxt;
  logic       out_vld_r, out_vld_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic       out_free;
  logic       out_load;

  assign out_free = !out_vld_r || out_ch.ready;
  // The held item is only known to be the last of its tick once the scan ends,
  // so it leaves with last clear when a newer item pushes it out.
  assign out_load = (ctl.push && hold_vld_r) || (ctl.flush && hold_vld_r) || ctl.answer;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    out_item_nxt = out_item_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    if (ctl.push) begin
      if (hold_vld_r) begin
        out_item_nxt      = hold_r;
        out_item_nxt.last = 1'b0;
      end
      hold_vld_nxt   = 1'b1;
      hold_nxt.kind  = KIND_RETX;
      hold_nxt.found = 1'b0;
      hold_nxt.data  = ctl.data;
      hold_nxt.group = ctl.group;
      hold_nxt.last  = 1'b0;
    end else if (ctl.flush) begin
      if (hold_vld_r) begin
        out_item_nxt      = hold_r;
        out_item_nxt.last = 1'b1;
      end
      hold_vld_nxt = 1'b0;
    end else if (ctl.answer) begin
      out_item_nxt.kind  = KIND_ANSWER;
      out_item_nxt.found = ctl.found;
      out_item_nxt.data  = '0;
      out_item_nxt.group = '0;
      out_item_nxt.last  = 1'b1;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_item_r <= out_item_nxt;
  end

  assign sts.can_push = !hold_vld_r || out_free;
  assign sts.out_free = out_free;
  assign sts.hold_vld = hold_vld_r;

  assign out_ch.valid         = out_vld_r;
  assign out_ch.kind          = out_item_r.kind;
  assign out_ch.found         = out_item_r.found;
  assign out_ch.out_tag_id    = out_item_r.data.tag;
  assign out_ch.out_logger_id = out_item_r.data.logger;
  assign out_ch.out_time      = out_item_r.data.stamp;
  assign out_ch.out_rssi      = out_item_r.data.rssi;
  assign out_ch.out_group     = out_item_r.group;
  assign out_ch.last          = out_item_r.last;

  `RDT_ASSERT_IMPL(a_load_needs_room, out_load, out_free, "output register overwritten")
  `RDT_ASSERT_IMPL(a_answer_no_hold, ctl.answer, !hold_vld_r, "answer while a retransmit is held")
  `RDT_ASSERT_NEXT(a_flush_marks_last, ctl.flush && hold_vld_r, out_vld_r && out_item_r.last,
                   "flushed item not marked last")

endmodule
`default_nettype wire

>>> sv/rdt_seq.sv
// Sequencer: takes input items, writes records, and steps the shared slot
// compare over the entry store for ticks and queries. Depends on rdt_pkg.
`default_nettype none
`include "retransmit_dedup_table_defines.svh"
module rdt_seq #(
  parameter int DEPTH            = 8,
  parameter int RETRANSMIT_COUNT = 3,
  parameter int CNT_W            = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rdt_pkg::OP_W-1:0]      in_op,
  input  wire rdt_pkg::entry_t               in_entry,
  input  wire logic                          cfg_we,
  input  wire logic [rdt_pkg::GROUP_W-1:0]   cfg_wdata,
  output logic [$clog2(DEPTH)-1:0]           mem_wr_addr,
  output logic                               mem_wr_pay_en,
  output logic                               mem_wr_cnt_en,
  output rdt_pkg::entry_t                    mem_wr_entry,
  output logic [CNT_W-1:0]                   mem_wr_cnt,
  output logic                               mem_rd_en,
  output logic [$clog2(DEPTH)-1:0]           mem_rd_addr,
  input  wire rdt_pkg::entry_t               mem_rd_entry,
  input  wire logic [CNT_W-1:0]              mem_rd_cnt,
  output rdt_pkg::out_ctl_t                  out_ctl,
  input  wire rdt_pkg::out_sts_t             out_sts
);
  import rdt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  entry_t              key_r, key_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       wslot_r, wslot_nxt;
  logic [GROUP_W-1:0]  logger_group_r, logger_group_nxt;

  logic accept;
  logic chk_last;
  logic match;
  logic emit;
  logic stall;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign chk_last = (chk_idx_r == LAST_SLOT);
  // The one compare unit: the slot in the registered read output against the query keys.
  assign match    = (mem_rd_entry == key_r);
  assign emit     = (op_r == OP_TICK) && (mem_rd_cnt != '0);
  assign stall    = emit && !out_sts.can_push;

  assign logger_group_nxt = cfg_we ? cfg_wdata : logger_group_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    chk_idx_nxt   = chk_idx_r;
    found_nxt     = found_r;
    wslot_nxt     = wslot_r;
    mem_wr_addr   = chk_idx_r;
    mem_wr_pay_en = 1'b0;
    mem_wr_cnt_en = 1'b0;
    mem_wr_entry  = in_entry;
    mem_wr_cnt    = mem_rd_cnt - 1'b1;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = chk_idx_r + 1'b1;
    out_ctl       = '0;
    out_ctl.data  = mem_rd_entry;
    out_ctl.group = logger_group_r;
    out_ctl.found = found_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_RECORD: begin
              // The pointer moves before the write, so the first record
              // after reset lands in slot one.
              wslot_nxt     = (wslot_r == LAST_SLOT) ? '0 : wslot_r + 1'b1;
              mem_wr_addr   = wslot_nxt;
              mem_wr_pay_en = 1'b1;
              mem_wr_cnt_en = 1'b1;
              mem_wr_cnt    = CNT_W'(RETRANSMIT_COUNT);
            end
            OP_TICK, OP_QUERY: begin
              op_nxt      = in_op;
              key_nxt     = in_entry;
              chk_idx_nxt = '0;
              found_nxt   = 1'b0;
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_nxt   = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (emit) begin
            mem_wr_cnt_en = 1'b1;
            out_ctl.push  = 1'b1;
          end
          if ((op_r == OP_QUERY) && match) begin
            found_nxt = 1'b1;
          end
          if (chk_last) begin
            state_nxt = ST_FLUSH;
          end else begin
            mem_rd_en   = 1'b1;
            chk_idx_nxt = chk_idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (op_r == OP_QUERY) begin
          if (out_sts.out_free) begin
            out_ctl.answer = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (!out_sts.hold_vld) begin
          state_nxt = ST_IDLE;
        end else if (out_sts.out_free) begin
          out_ctl.flush = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      wslot_r        <= '0;
      logger_group_r <= '0;
    end else begin
      state_r        <= state_nxt;
      wslot_r        <= wslot_nxt;
      logger_group_r <= logger_group_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    chk_idx_r <= chk_idx_nxt;
    found_r   <= found_nxt;
  end

  `RDT_ASSERT_IMPL(a_wb_in_scan, mem_wr_cnt_en && !mem_wr_pay_en, state_r == ST_SCAN,
                   "count write back outside a scan")
  `RDT_ASSERT_NEXT(a_scan_step, (state_r == ST_SCAN) && !stall && !chk_last,
                   (state_r == ST_SCAN) && (chk_idx_r == $past(chk_idx_r) + 1'b1),
                   "scan did not advance by one slot")
  `RDT_ASSERT_IMPL(a_push_has_room, out_ctl.push, out_sts.can_push,
                   "retransmit pushed into a full output stage")

endmodule
`default_nettype wire

>>> sv/retransmit_dedup_table.sv
// Retransmit dedup table, top level. A record is written as it is accepted.
// A tick or a query has a start step, then steps through every slot in turn
// through the shared compare over the registered memory read port, then a
// closing step; output stalls hold it. Results leave through an output register.
// Reset (rst_n, synchronous, active low) clears the valid bits, the write
// pointer and the group register at once; there is no clearing pass.
`default_nettype none
module retransmit_dedup_table #(
  parameter int DEPTH            = 8,
  parameter int RETRANSMIT_COUNT = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rdt_pkg::GROUP_W-1:0]  cfg_wdata,
  rdt_in_if.sink                            in_ch,
  rdt_out_if.source                         out_ch
);
  import rdt_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(RETRANSMIT_COUNT + 1);

  entry_t            in_entry;
  logic [AW-1:0]     mem_wr_addr;
  logic              mem_wr_pay_en;
  logic              mem_wr_cnt_en;
  entry_t            mem_wr_entry;
  logic [CNT_W-1:0]  mem_wr_cnt;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  entry_t            mem_rd_entry;
  logic [CNT_W-1:0]  mem_rd_cnt;
  out_ctl_t          out_ctl;
  out_sts_t          out_sts;

  assign in_entry.tag    = in_ch.tag_id;
  assign in_entry.logger = in_ch.logger_id;
  assign in_entry.stamp  = in_ch.pickup_time;
  assign in_entry.rssi   = in_ch.rssi;

  rdt_seq #(
    .DEPTH            (DEPTH),
    .RETRANSMIT_COUNT (RETRANSMIT_COUNT),
    .CNT_W            (CNT_W)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_op         (in_ch.operation),
    .in_entry      (in_entry),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_pay_en (mem_wr_pay_en),
    .mem_wr_cnt_en (mem_wr_cnt_en),
    .mem_wr_entry  (mem_wr_entry),
    .mem_wr_cnt    (mem_wr_cnt),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_entry  (mem_rd_entry),
    .mem_rd_cnt    (mem_rd_cnt),
    .out_ctl       (out_ctl),
    .out_sts       (out_sts)
  );

  rdt_entry_mem #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_addr   (mem_wr_addr),
    .wr_pay_en (mem_wr_pay_en),
    .wr_cnt_en (mem_wr_cnt_en),
    .wr_entry  (mem_wr_entry),
    .wr_cnt    (mem_wr_cnt),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_entry  (mem_rd_entry),
    .rd_cnt    (mem_rd_cnt)
  );

  rdt_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (out_ctl),
    .sts    (out_sts),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for retransmit_dedup_table: records, ticks and queries
// go in through the valid/ready channels, and every result is checked.
// Depends on rdt_pkg, the rdt_in_if/rdt_out_if interfaces and the table RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdt_pkg::*;

  localparam int DEPTH       = 8;
  localparam int RETX_COUNT  = 3;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [TAG_W-1:0]         tag;
    logic [LOG_W-1:0]         logger;
    logic [STAMP_W-1:0]       stamp;
    logic signed [RSSI_W-1:0] rssi;
  } pickup_t;

  typedef struct {
    logic                     kind;
    logic                     found;
    logic [TAG_W-1:0]         tag;
    logic [LOG_W-1:0]         logger;
    logic [STAMP_W-1:0]       stamp;
    logic signed [RSSI_W-1:0] rssi;
    logic [GROUP_W-1:0]       group;
    logic                     last;
  } result_t;

  // A row either has its answer written in (given) or leaves it to the predictor.
  typedef struct {
    pickup_t p;
    bit      given;
    bit      hit;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [GROUP_W-1:0] cfg_wdata;

  rdt_in_if  in_ch ();
  rdt_out_if out_ch ();

  retransmit_dedup_table #(
    .DEPTH            (DEPTH),
    .RETRANSMIT_COUNT (RETX_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predictor copy of the table.
  logic [TAG_W-1:0]         slot_tag    [DEPTH];
  logic [LOG_W-1:0]         slot_logger [DEPTH];
  logic [STAMP_W-1:0]       slot_stamp  [DEPTH];
  logic signed [RSSI_W-1:0] slot_rssi   [DEPTH];
  int                       slot_left   [DEPTH];
  int                       wr_slot;
  logic [GROUP_W-1:0]       group_now;

  result_t step_results [DEPTH];
  result_t awaited_results [$];
  pickup_t recent_records [$];

  int errors, results_seen, n_record, n_tick, n_query, n_hits, longest_burst;
  bit in_calm, out_calm, hold_req;

  row_t script [25] = '{
    '{'{OP_TICK,   32'h0,         32'h0,         40'h0,           8'h00}, 1'b1, 1'b0},
    '{'{OP_QUERY,  32'h0,         32'h0,         40'h0,           8'h00}, 1'b1, 1'b1},
    '{'{OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 8'hFF}, 1'b1, 1'b0},
    '{'{OP_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 8'hFF}, 1'b1, 1'b0},
    '{'{OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 8'h7F}, 1'b1, 1'b0},
    '{'{OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 8'h7F}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'h0,         32'h0,         40'h0,           8'h80}, 1'b1, 1'b0},
    '{'{OP_QUERY,  32'h0,         32'h0,         40'h0,           8'h80}, 1'b0, 1'b0},
    '{'{OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFE, 8'h7F}, 1'b0, 1'b0},
    '{'{OP_TICK,   32'h0,         32'h0,         40'h0,           8'h00}, 1'b0, 1'b0},
    '{'{OP_TICK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 8'hFF}, 1'b0, 1'b0},
    '{'{OP_TICK,   32'h0,         32'h0,         40'h0,           8'h00}, 1'b0, 1'b0},
    '{'{OP_TICK,   32'h0,         32'h0,         40'h0,           8'h00}, 1'b0, 1'b0},
    '{'{OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 8'h7F}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'h0000_0001, 32'h8000_0000, 40'h00_0000_0001, 8'h01}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'hAAAA_AAAA, 32'h5555_5555, 40'hAA_AAAA_AAAA, 8'hAA}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'h5555_5555, 32'hAAAA_AAAA, 40'h55_5555_5555, 8'h55}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'h1234_5678, 32'h9ABC_DEF0, 40'h12_3456_789A, 8'h12}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'hDEAD_BEEF, 32'h0BAD_F00D, 40'hFE_DCBA_9876, 8'hFE}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'h8000_0000, 32'h0000_0001, 40'h80_0000_0000, 8'h80}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 40'h7F_FFFF_FFFF, 8'h7F}, 1'b0, 1'b0},
    '{'{OP_RECORD, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 40'h0F_0F0F_0F0F, 8'h00}, 1'b0, 1'b0},
    '{'{OP_TICK,   32'h0,         32'h0,         40'h0,           8'h00}, 1'b0, 1'b0},
    '{'{OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 8'h7F}, 1'b0, 1'b0},
    '{'{OP_QUERY,  32'h1234_5678, 32'h9ABC_DEF0, 40'h12_3456_789A, 8'h12}, 1'b0, 1'b0}
  };

  function automatic void clear_table();
    for (int i = 0; i < DEPTH; i++) begin
      slot_tag[i]    = '0;
      slot_logger[i] = '0;
      slot_stamp[i]  = '0;
      slot_rssi[i]   = '0;
      slot_left[i]   = 0;
    end
    wr_slot   = 0;
    group_now = '0;
  endfunction

  // Applies one item to the predicted table; fills step_results, returns their number.
  function automatic int step_table(input pickup_t p);
    result_t r;
    int      n;
    bit      hit;
    n = 0;
    r = '{default: '0};
    case (p.op)
      OP_RECORD: begin
        wr_slot = (wr_slot + 1) % DEPTH;
        slot_tag[wr_slot]    = p.tag;
        slot_logger[wr_slot] = p.logger;
        slot_stamp[wr_slot]  = p.stamp;
        slot_rssi[wr_slot]   = p.rssi;
        slot_left[wr_slot]   = RETX_COUNT;
      end
      OP_TICK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_left[i] != 0) begin
            r.kind   = KIND_RETX;
            r.tag    = slot_tag[i];
            r.logger = slot_logger[i];
            r.stamp  = slot_stamp[i];
            r.rssi   = slot_rssi[i];
            r.group  = group_now;
            step_results[n] = r;
            n++;
            slot_left[i]--;
          end
        end
        if (n > 0) begin
          step_results[n-1].last = 1'b1;
        end
      end
      OP_QUERY: begin
        // Spent slots still take part in the compare.
        hit = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_tag[i] == p.tag && slot_logger[i] == p.logger &&
              slot_stamp[i] == p.stamp && slot_rssi[i] == p.rssi) begin
            hit = 1'b1;
          end
        end
        r.kind  = KIND_ANSWER;
        r.found = hit;
        r.last  = 1'b1;
        step_results[0] = r;
        n = 1;
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  function automatic void note_accepted(input pickup_t p, input bit given, input bit hit);
    int n;
    n = step_table(p);
    if (given) begin
      // A written-in row only ever expects a query answer or nothing at all.
      n = 0;
      if (p.op == OP_QUERY) begin
        step_results[0] = '{default: '0};
        step_results[0].kind  = KIND_ANSWER;
        step_results[0].found = hit;
        step_results[0].last  = 1'b1;
        n = 1;
      end
    end
    for (int k = 0; k < n; k++) begin
      awaited_results.push_back(step_results[k]);
    end
    case (p.op)
      OP_RECORD: n_record++;
      OP_TICK: begin
        n_tick++;
        if (n > longest_burst) begin
          longest_burst = n;
        end
      end
      OP_QUERY: begin
        n_query++;
        if (step_results[0].found) begin
          n_hits++;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("%0t ns: %s: got %0h, wanted %0h", $time, what, got, want);
  endtask

  // Sender: waits its drawn gap, offers the item and holds it until accepted.
  task automatic offer(input pickup_t p, input bit given, input bit hit);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= p.op;
    in_ch.tag_id      <= p.tag;
    in_ch.logger_id   <= p.logger;
    in_ch.pickup_time <= p.stamp;
    in_ch.rssi        <= p.rssi;
    do @(posedge clk); while (!in_ch.ready);
    note_accepted(p, given, hit);
  endtask

  function automatic pickup_t random_pickup(input int pinned);
    pickup_t p;
    int      pick;
    int      field;
    p.tag    = $urandom;
    p.logger = $urandom;
    p.stamp  = STAMP_W'({$urandom, $urandom});
    p.rssi   = RSSI_W'($urandom);
    pick = (pinned >= 0) ? pinned : $urandom_range(0, 99);
    if (pick < 40) begin
      p.op = OP_RECORD;
      recent_records.push_back(p);
      if (recent_records.size() > 12) begin
        void'(recent_records.pop_front());
      end
    end else if (pick < 65) begin
      p.op = OP_TICK;
    end else if (pick < 95) begin
      // Mostly ask about something recently recorded, sometimes with one bit off.
      if (recent_records.size() > 0 && $urandom_range(0, 3) != 0) begin
        p = recent_records[$urandom_range(0, recent_records.size() - 1)];
        if ($urandom_range(0, 2) == 0) begin
          field = $urandom_range(0, 3);
          case (field)
            0: p.tag    ^= TAG_W'(1) << $urandom_range(0, TAG_W - 1);
            1: p.logger ^= LOG_W'(1) << $urandom_range(0, LOG_W - 1);
            2: p.stamp  ^= STAMP_W'(1) << $urandom_range(0, STAMP_W - 1);
            default: p.rssi ^= RSSI_W'(1) << $urandom_range(0, RSSI_W - 1);
          endcase
        end
      end
      p.op = OP_QUERY;
    end else begin
      p.op = OP_SPARE;
    end
    return p;
  endfunction

  task automatic run_random(input int count);
    int      counted;
    pickup_t p;
    counted = 0;
    while (counted < count) begin
      if (counted % 16 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      p = random_pickup(-1);
      offer(p, 1'b0, 1'b0);
      if (p.op != OP_SPARE) begin
        counted++;
      end
    end
  endtask

  // Lowers valid, waits for every awaited result, then lets the block go quiet.
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (awaited_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() > 0) begin
      report("results never delivered", awaited_results.size(), 0);
      awaited_results.delete();
    end
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_group(input logic [GROUP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    group_now = value;
  endtask

  task automatic take_result();
    result_t got;
    result_t want;
    got.kind   = out_ch.kind;
    got.found  = out_ch.found;
    got.tag    = out_ch.out_tag_id;
    got.logger = out_ch.out_logger_id;
    got.stamp  = out_ch.out_time;
    got.rssi   = out_ch.out_rssi;
    got.group  = out_ch.out_group;
    got.last   = out_ch.last;
    results_seen++;
    if (awaited_results.size() == 0) begin
      report("result with nothing awaited, kind", got.kind, 0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind !== want.kind) report("kind", got.kind, want.kind);
    if (got.found !== want.found) report("found", got.found, want.found);
    if (got.tag !== want.tag) report("out_tag_id", got.tag, want.tag);
    if (got.logger !== want.logger) report("out_logger_id", got.logger, want.logger);
    if (got.stamp !== want.stamp) report("out_time", got.stamp, want.stamp);
    if (got.rssi !== want.rssi) report("out_rssi", got.rssi, want.rssi);
    if (got.group !== want.group) report("out_group", got.group, want.group);
    if (got.last !== want.last) report("last", got.last, want.last);
  endtask

  // Receiver: random stalls per item, plus one long hold-off when asked.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = out_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && !hold_req);
      if (out_ch.valid) begin
        take_result();
      end
    end
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_RECORD;
    in_ch.tag_id      <= '0;
    in_ch.logger_id   <= '0;
    in_ch.pickup_time <= '0;
    in_ch.rssi        <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    errors = 0;
    results_seen = 0;
    n_record = 0;
    n_tick = 0;
    n_query = 0;
    n_hits = 0;
    longest_burst = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    hold_req = 1'b0;
    clear_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      offer(script[i].p, script[i].given, script[i].hit);
    end
    settle();

    write_group(16'hFFFF);
    run_random(30);
    settle();

    write_group(16'h0000);
    run_random(30);
    settle();

    // Back-to-back records and ticks against a stalled receiver fill the block.
    write_group(GROUP_W'($urandom));
    hold_req = 1'b1;
    in_calm  = 1'b1;
    for (int k = 0; k < 12; k++) begin
      offer(random_pickup((k % 3 == 2) ? 50 : 0), 1'b0, 1'b0);
    end
    run_random(20);
    settle();

    $display("Covered %0d records, %0d ticks and %0d queries (%0d found) over four group settings.",
             n_record, n_tick, n_query, n_hits);
    $display("Checked %0d results; the largest tick gave %0d retransmits.",
             results_seen, longest_burst);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rdt_pkg.sv
sv/rdt_if.sv
sv/rdt_entry_mem.sv
sv/rdt_out_stage.sv
sv/rdt_seq.sv
sv/retransmit_dedup_table.sv
dv/tb.sv
